// ===== design/ttlx_pkg.sv =====
// Shared types and constants for the TTL expiry table.
// No dependencies; imported by ttl_expiry_table_core.
`default_nettype none

package ttlx_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // One table row as held in the entry memory.
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] lifetime;
    logic [DATA_W-1:0] elapsed;
    logic              sliding;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/ttlx_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the entry store of the TTL expiry table.
`default_nettype none

module ttlx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ttl_expiry_table_core.sv =====
// Top level of the TTL expiry table: sequencer, valid bits and result register.
// Depends on ttlx_pkg (types, codes) and ttlx_ram (entry memory).
//
// Usage:
//  - Issue a transaction by raising start with cmd_i and its operands; it is
//    taken at a rising edge where start is high and busy is low.
//  - Clear answers in the cycle right after acceptance and leaves busy low, so
//    another transaction can be taken at the next edge. Unused command codes
//    answer the same way, with all result fields zero.
//  - Add, get, remove and tick walk every row of the entry memory, one read a
//    cycle, so their result appears only after the S_SCAN and S_FIN states, and
//    busy falls as the result appears: the single read port of the entry memory
//    sets the length of the scan. Tick writes each updated row back in the cycle
//    after its read; add, and a get that hits a sliding entry, write one row in
//    the final cycle.
//  - The result appears for exactly one cycle with done_o high; the receiver
//    cannot stall it, so it must take it in that cycle.
//  - Reset clears every valid bit at once; row contents need no clearing
//    because only rows marked valid are ever interpreted.
`default_nettype none

module ttl_expiry_table_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [ttlx_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [ttlx_pkg::DATA_W-1:0]     key_i,
  input  wire logic [ttlx_pkg::DATA_W-1:0]     payload_i,
  input  wire logic [ttlx_pkg::DATA_W-1:0]     lifetime_i,
  input  wire logic                            sliding_i,
  input  wire logic [ttlx_pkg::DATA_W-1:0]     delta_i,
  output logic                                 done_o,
  output logic                                 hit_o,
  output logic      [ttlx_pkg::DATA_W-1:0]     value_o,
  output logic      [ttlx_pkg::STATUS_W-1:0]   status_o,
  output logic      [ttlx_pkg::CNT_W-1:0]      evicted_count_o
);

  import ttlx_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [ENTRIES-1:0]  valid_q;

  // Latched transaction.
  cmd_e                cmd_q;
  logic [DATA_W-1:0]   key_q;
  logic [DATA_W-1:0]   payload_q;
  logic [DATA_W-1:0]   lifetime_q;
  logic                sliding_q;
  logic [DATA_W-1:0]   delta_q;

  // Scan pipeline: read issue and compare stages.
  logic [IDX_W-1:0]    rd_idx_q;
  logic                rd_go_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                cmp_vld_q;

  // Scan findings.
  logic                found_q;
  logic [IDX_W-1:0]    found_idx_q;
  entry_t              found_row_q;
  logic                free_ok_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic [CNT_W-1:0]    evict_cnt_q;

  // Result register.
  logic                done_q;
  logic                hit_q;
  logic [DATA_W-1:0]   value_q;
  status_e             status_q;
  logic [CNT_W-1:0]    evicted_q;

  // Memory ports.
  entry_t              rd_row;
  entry_t              wr_row;
  logic [$bits(entry_t)-1:0] rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;

  logic                row_live;
  logic                key_match;
  logic [DATA_W:0]     elapsed_sum;
  logic [DATA_W-1:0]   elapsed_d;
  logic                expired;

  assign rd_row    = entry_t'(rd_data);
  assign row_live  = cmp_vld_q && valid_q[cmp_idx_q];
  assign key_match = row_live && (rd_row.key == key_q);

  // Saturating elapsed-time update for tick.
  assign elapsed_sum = {1'b0, rd_row.elapsed} + {1'b0, delta_q};
  assign elapsed_d   = elapsed_sum[DATA_W] ? '1 : elapsed_sum[DATA_W-1:0];
  assign expired     = elapsed_d >= rd_row.lifetime;

  // Write port: tick write-back during the scan, single-row update at the end.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmp_idx_q;
    wr_row    = rd_row;
    wr_row.elapsed = elapsed_d;
    if (state_q == S_SCAN) begin
      mem_we = row_live && (cmd_q == CMD_TICK);
    end else if (state_q == S_FIN) begin
      if (cmd_q == CMD_ADD) begin
        mem_we    = found_q || free_ok_q;
        mem_waddr = found_q ? found_idx_q : free_idx_q;
        wr_row    = '{key: key_q, payload: payload_q, lifetime: lifetime_q,
                      elapsed: '0, sliding: sliding_q};
      end else if (cmd_q == CMD_GET) begin
        // A hit on a sliding entry restarts its clock.
        mem_we    = found_q && found_row_q.sliding;
        mem_waddr = found_idx_q;
        wr_row    = found_row_q;
        wr_row.elapsed = '0;
      end
    end
  end

  ttlx_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_row),
    .re_i    (rd_go_q),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cmd_q       <= CMD_ADD;
      key_q       <= '0;
      payload_q   <= '0;
      lifetime_q  <= '0;
      sliding_q   <= 1'b0;
      delta_q     <= '0;
      rd_idx_q    <= '0;
      rd_go_q     <= 1'b0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      found_row_q <= '0;
      free_ok_q   <= 1'b0;
      free_idx_q  <= '0;
      evict_cnt_q <= '0;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      value_q     <= '0;
      status_q    <= ST_OK;
      evicted_q   <= '0;
    end else begin
      done_q    <= 1'b0;
      cmp_vld_q <= rd_go_q;
      cmp_idx_q <= rd_idx_q;

      // Advance the read pointer; stop after the last row.
      if (rd_go_q) begin
        if (rd_idx_q == LAST_IDX) begin
          rd_go_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q       <= cmd_e'(cmd_i);
            key_q       <= key_i;
            payload_q   <= payload_i;
            lifetime_q  <= lifetime_i;
            sliding_q   <= sliding_i;
            delta_q     <= delta_i;
            found_q     <= 1'b0;
            free_ok_q   <= 1'b0;
            evict_cnt_q <= '0;
            case (cmd_e'(cmd_i))
              CMD_ADD, CMD_GET, CMD_REMOVE, CMD_TICK: begin
                state_q  <= S_SCAN;
                rd_idx_q <= '0;
                rd_go_q  <= 1'b1;
              end
              CMD_CLEAR: begin
                valid_q   <= '0;
                done_q    <= 1'b1;
                hit_q     <= 1'b0;
                value_q   <= '0;
                status_q  <= ST_OK;
                evicted_q <= '0;
              end
              default: begin
                // Unused codes: answer with an all-zero result.
                done_q    <= 1'b1;
                hit_q     <= 1'b0;
                value_q   <= '0;
                status_q  <= ST_OK;
                evicted_q <= '0;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (cmp_vld_q) begin
            if (key_match && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= cmp_idx_q;
              found_row_q <= rd_row;
            end
            if (!valid_q[cmp_idx_q] && !free_ok_q) begin
              free_ok_q  <= 1'b1;
              free_idx_q <= cmp_idx_q;
            end
            if (cmd_q == CMD_TICK && row_live && expired) begin
              valid_q[cmp_idx_q] <= 1'b0;
              if (evict_cnt_q != CNT_MAX) begin
                evict_cnt_q <= evict_cnt_q + 1'b1;
              end
            end
            if (cmp_idx_q == LAST_IDX) begin
              state_q <= S_FIN;
            end
          end
        end

        S_FIN: begin
          state_q   <= S_IDLE;
          done_q    <= 1'b1;
          hit_q     <= 1'b0;
          value_q   <= '0;
          status_q  <= ST_OK;
          evicted_q <= '0;
          case (cmd_q)
            CMD_ADD: begin
              if (found_q) begin
                valid_q[found_idx_q] <= 1'b1;
              end else if (free_ok_q) begin
                valid_q[free_idx_q] <= 1'b1;
              end else begin
                status_q <= ST_FULL;
              end
            end
            CMD_GET: begin
              hit_q    <= found_q;
              value_q  <= found_q ? found_row_q.payload : '0;
              status_q <= found_q ? ST_OK : ST_MISS;
            end
            CMD_REMOVE: begin
              hit_q    <= found_q;
              status_q <= found_q ? ST_OK : ST_MISS;
              if (found_q) begin
                valid_q[found_idx_q] <= 1'b0;
              end
            end
            CMD_TICK: begin
              evicted_q <= evict_cnt_q;
            end
            default: begin
              hit_q <= 1'b0;
            end
          endcase
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign value_o         = value_q;
  assign status_o        = status_q;
  assign evicted_count_o = evicted_q;

  // The result strobe always coincides with readiness for the next transaction.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Clear empties the table and answers in the next cycle.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_CLEAR) |=> (done_o && valid_q == '0))
    else $error("clear did not empty the table");

  // A full status is only reported when every row is occupied.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (&valid_q))
    else $error("full status with a free row");

  // Only a tick result reports evictions.
  a_evict_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_count_o != '0) |-> (cmd_q == CMD_TICK))
    else $error("eviction count outside a tick result");

  // Memory write port is idle whenever no transaction is in progress.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_we)
    else $error("entry memory written while idle");

endmodule

`default_nettype wire
